[rtl/bftr_pkg.sv]
// Package for the bitmap toggle/flip/rotate block.
// Holds sizes, field codes, the command type and bit helpers; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bftr_pkg;

  localparam int MAX_SIDE = 16;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int IDX_W    = $clog2(MAX_SIDE);

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [1:0] MODE_TOGGLE = 2'd0;
  localparam logic [1:0] MODE_MIRROR = 2'd1;
  localparam logic [1:0] MODE_ROTATE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_MODE  = 2'd2;

  typedef enum logic [2:0] {
    K_TOGGLE,
    K_MIRROR,
    K_ROTATE,
    K_ERR_RANGE,
    K_ERR_MODE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] row_idx;
    logic [IDX_W-1:0] col_idx;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  function automatic logic [MAX_SIDE-1:0] side_mask(input logic [SIDE_W-1:0] n);
    logic [MAX_SIDE:0] t;
    t = ({{MAX_SIDE{1'b0}}, 1'b1} << n) - {{MAX_SIDE{1'b0}}, 1'b1};
    return t[MAX_SIDE-1:0];
  endfunction

  function automatic logic [MAX_SIDE-1:0] bit_rev(input logic [MAX_SIDE-1:0] v);
    logic [MAX_SIDE-1:0] r;
    for (int k = 0; k < MAX_SIDE; k++) r[k] = v[MAX_SIDE-1-k];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/bftr_in_if.sv]
// Input channel of the bitmap block: valid/ready handshake with one request.
// Uses the field widths of bftr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bftr_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [bftr_pkg::SIDE_W-1:0] row;
  logic [bftr_pkg::SIDE_W-1:0] col;

  modport source (output valid, output mode, output row, output col, input ready);
  modport sink   (input valid, input mode, input row, input col, output ready);
endinterface

`default_nettype wire

[rtl/bftr_out_if.sv]
// Result channel of the bitmap block: valid/ready handshake with one row word.
// Uses the field widths of bftr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bftr_out_if;
  logic                          valid;
  logic                          ready;
  logic [bftr_pkg::MAX_SIDE-1:0] row_bits;
  logic [bftr_pkg::SIDE_W-1:0]   row_number;
  logic [1:0]                    status;
  logic                          last;

  modport source (output valid, output row_bits, output row_number, output status,
                  output last, input ready);
  modport sink   (input valid, input row_bits, input row_number, input status,
                  input last, output ready);
endinterface

`default_nettype wire

[rtl/bftr_front.sv]
// Front end: takes requests from the input channel and classifies them into commands.
// Depends on bftr_pkg and bftr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module bftr_front (
  bftr_in_if.sink                     in_ch,
  input  wire logic [bftr_pkg::SIDE_W-1:0] side,
  input  wire logic                   q_full,
  output bftr_pkg::cmd_t              cmd,
  output logic                        push
);

  logic in_range;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign in_range = (in_ch.row != '0) && (in_ch.row <= side) &&
                    (in_ch.col != '0) && (in_ch.col <= side);

  always_comb begin
    cmd.row_idx = bftr_pkg::IDX_W'(in_ch.row - bftr_pkg::SIDE_W'(1));
    cmd.col_idx = bftr_pkg::IDX_W'(in_ch.col - bftr_pkg::SIDE_W'(1));
    case (in_ch.mode)
      bftr_pkg::MODE_TOGGLE: cmd.kind = in_range ? bftr_pkg::K_TOGGLE
                                                 : bftr_pkg::K_ERR_RANGE;
      bftr_pkg::MODE_MIRROR: cmd.kind = bftr_pkg::K_MIRROR;
      bftr_pkg::MODE_ROTATE: cmd.kind = bftr_pkg::K_ROTATE;
      default:               cmd.kind = bftr_pkg::K_ERR_MODE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/bftr_queue.sv]
// Short command queue between the front end and the back end.
// Depends on bftr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bftr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bftr_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output bftr_pkg::cmd_t      head,
  output logic                q_vld,
  output logic                q_full
);

  bftr_pkg::cmd_t                 ent_r [bftr_pkg::QDEPTH];
  logic [bftr_pkg::QPTR_W-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [bftr_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign q_full  = (cnt_r == bftr_pkg::QCNT_W'(bftr_pkg::QDEPTH));
  assign q_vld   = (cnt_r != '0);
  assign head    = ent_r[rp_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_vld;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == bftr_pkg::QPTR_W'(bftr_pkg::QDEPTH - 1)) ? '0
               : wp_r + bftr_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == bftr_pkg::QPTR_W'(bftr_pkg::QDEPTH - 1)) ? '0
               : rp_r + bftr_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + bftr_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - bftr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[rtl/bftr_back.sv]
// Back end: holds the image, carries out commands one row a cycle while the result slot is free, and drives results.
// Depends on bftr_pkg and bftr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module bftr_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [bftr_pkg::SIDE_W-1:0] side,
  input  wire bftr_pkg::cmd_t              head,
  input  wire logic                        q_vld,
  output logic                             pop,
  bftr_out_if.source                       out_ch
);

  localparam int MS = bftr_pkg::MAX_SIDE;
  localparam int SW = bftr_pkg::SIDE_W;
  localparam int IW = bftr_pkg::IDX_W;

  bftr_pkg::back_state_t state_r, state_nxt;
  bftr_pkg::cmd_t        cmd_r;
  logic [MS-1:0]         img_r [MS];
  logic [MS-1:0]         old_r [MS];
  logic [IW-1:0]         cnt_r, cnt_nxt;

  logic                  out_vld_r, out_vld_nxt;
  logic [MS-1:0]         out_bits_r;
  logic [SW-1:0]         out_num_r;
  logic [1:0]            out_st_r;
  logic                  out_last_r;

  logic                  slot_free, head_err, last_row;
  logic                  snap, ld_err, ld_row;
  logic [MS-1:0]         mask, cur, col_vec, mir_row, rot_row, tgl_row, new_row;
  logic [SW-1:0]         row_num, rsh;

  assign slot_free = !out_vld_r || out_ch.ready;
  assign head_err  = (head.kind == bftr_pkg::K_ERR_RANGE) ||
                     (head.kind == bftr_pkg::K_ERR_MODE);
  assign row_num   = SW'(cnt_r) + SW'(1);
  assign last_row  = (row_num == side);
  assign mask      = bftr_pkg::side_mask(side);
  assign rsh       = SW'(MS) - side;
  assign cur       = img_r[cnt_r];

  always_comb begin
    for (int k = 0; k < MS; k++) col_vec[k] = old_r[k][cnt_r];
  end

  assign mir_row = ((bftr_pkg::bit_rev(cur) >> rsh) & mask) | (cur & ~mask);
  assign rot_row = ((bftr_pkg::bit_rev(col_vec) >> rsh) & mask) | (cur & ~mask);
  assign tgl_row = cur ^ ((cnt_r == cmd_r.row_idx) ?
                          ({{(MS-1){1'b0}}, 1'b1} << cmd_r.col_idx) : '0);

  always_comb begin
    case (cmd_r.kind)
      bftr_pkg::K_MIRROR: new_row = mir_row;
      bftr_pkg::K_ROTATE: new_row = rot_row;
      default:            new_row = tgl_row;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bftr_pkg::B_IDLE: begin
        if (q_vld && slot_free && !head_err) state_nxt = bftr_pkg::B_RUN;
      end
      bftr_pkg::B_RUN: begin
        if (slot_free && last_row) state_nxt = bftr_pkg::B_IDLE;
      end
      default: state_nxt = bftr_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    snap   = 1'b0;
    ld_err = 1'b0;
    ld_row = 1'b0;
    case (state_r)
      bftr_pkg::B_IDLE: begin
        pop    = q_vld && slot_free;
        snap   = pop && !head_err;
        ld_err = pop && head_err;
      end
      bftr_pkg::B_RUN: begin
        ld_row = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (snap) begin
      cnt_nxt = '0;
    end else if (ld_row) begin
      cnt_nxt = cnt_r + IW'(1);
    end
    out_vld_nxt = (ld_err || ld_row) ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bftr_pkg::B_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      for (int k = 0; k < MS; k++) img_r[k] <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
      if (ld_row) img_r[cnt_r] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (snap) begin
      cmd_r <= head;
      for (int k = 0; k < MS; k++) old_r[k] <= img_r[k];
    end
    if (ld_err) begin
      out_bits_r <= '0;
      out_num_r  <= '0;
      out_st_r   <= (head.kind == bftr_pkg::K_ERR_RANGE) ? bftr_pkg::ST_RANGE
                                                         : bftr_pkg::ST_MODE;
      out_last_r <= 1'b1;
    end else if (ld_row) begin
      out_bits_r <= new_row & mask;
      out_num_r  <= row_num;
      out_st_r   <= bftr_pkg::ST_OK;
      out_last_r <= last_row;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.row_bits   = out_bits_r;
  assign out_ch.row_number = out_num_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.last       = out_last_r;

endmodule

`default_nettype wire

[rtl/bitmap_toggle_flip_rotate.sv]
// Top level of the square bitmap block: toggle a pixel, mirror rows, rotate clockwise.
// Depends on bftr_pkg, bftr_in_if, bftr_out_if, bftr_front, bftr_queue and bftr_back.
//
// Usage:
//   in_ch carries one request (mode, row, col); it is taken when valid and ready are high.
//   out_ch carries result words (row_bits, row_number, status, last) the same way.
//   cfg_we/cfg_wdata write the side length; a value of 0 acts as 1, above 16 as 16.
//   Write the side only while no request is pending or being answered.
// A valid request passes the command queue and the command register before its first
//   result word is registered; an error word is registered straight from the queue head.
// Throughput: a valid operation gives side results, one per cycle while the receiver
//   takes them; an error request gives one result. The row engine rewrites one image
//   row per cycle while the result slot is free.
// A two-entry command queue lets requests be taken while the row engine works.
// Reset clears the image, sets the side to 16 and empties the queue.
// When the receiver stalls, the result word holds and the row engine waits; the
// queue keeps taking requests until it is full, then in_ch.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_toggle_flip_rotate (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bftr_in_if.sink                          in_ch,
  bftr_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [bftr_pkg::SIDE_W-1:0] cfg_wdata
);

  logic [bftr_pkg::SIDE_W-1:0] size_r, size_nxt;
  logic [bftr_pkg::SIDE_W-1:0] side;
  bftr_pkg::cmd_t              push_cmd, head;
  logic                        push, pop, q_vld, q_full;

  assign size_nxt = cfg_we ? cfg_wdata : size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= bftr_pkg::SIDE_W'(bftr_pkg::MAX_SIDE);
    end else begin
      size_r <= size_nxt;
    end
  end

  assign side = (size_r == '0) ? bftr_pkg::SIDE_W'(1) :
                (size_r > bftr_pkg::SIDE_W'(bftr_pkg::MAX_SIDE)) ?
                bftr_pkg::SIDE_W'(bftr_pkg::MAX_SIDE) : size_r;

  bftr_front u_front (
    .in_ch  (in_ch),
    .side   (side),
    .q_full (q_full),
    .cmd    (push_cmd),
    .push   (push)
  );

  bftr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_vld    (q_vld),
    .q_full   (q_full)
  );

  bftr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .side   (side),
    .head   (head),
    .q_vld  (q_vld),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != bftr_pkg::ST_OK) |->
      (out_ch.last && out_ch.row_number == '0 && out_ch.row_bits == '0))
    else $error("error result is not a single cleared word");

  a_row_in_side: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == bftr_pkg::ST_OK) |->
      (out_ch.row_number != '0 && out_ch.row_number <= side &&
       out_ch.last == (out_ch.row_number == side)))
    else $error("row number outside the side or last flag misplaced");

  a_cols_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.row_bits & ~bftr_pkg::side_mask(side)) == '0))
    else $error("columns beyond the side are not zero");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_vld)
    else $error("command queue popped while empty");

endmodule

`default_nettype wire

[dv/bftr_checker.sv]
// Checker for the bitmap toggle/flip/rotate block: keeps its own image and side,
// predicts the row words of each request and compares them with the result channel.
// Depends on bftr_pkg, bftr_in_if and bftr_out_if.
`timescale 1ns / 1ps

module bftr_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  bftr_in_if                          in_mon,
  bftr_out_if                         out_mon,
  input  logic                        cfg_we,
  input  logic [bftr_pkg::SIDE_W-1:0] cfg_wdata,
  output int                          fail_count,
  output int                          words_due
);
  import bftr_pkg::*;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [MAX_SIDE-1:0] bits;
    logic [SIDE_W-1:0]   num;
    logic [1:0]          status;
    logic                last;
  } row_word_t;

  logic [MAX_SIDE-1:0] image [MAX_SIDE];
  logic [SIDE_W-1:0]   side_reg;
  row_word_t           row_words_due[$];

  initial begin
    fail_count = 0;
    words_due  = 0;
  end

  task automatic report(input string msg);
    if (fail_count < PRINT_CAP) begin
      $display("%0t ns: %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic int active_side(input logic [SIDE_W-1:0] s);
    if (s == 0) begin
      return 1;
    end
    if (s > MAX_SIDE) begin
      return MAX_SIDE;
    end
    return int'(s);
  endfunction

  task automatic apply_request(input logic [1:0] mode, input logic [SIDE_W-1:0] r,
                               input logic [SIDE_W-1:0] c);
    int                  n;
    logic [MAX_SIDE-1:0] keep;
    logic [MAX_SIDE-1:0] src;
    logic [MAX_SIDE-1:0] prev [MAX_SIDE];
    n = active_side(side_reg);
    keep = '1;
    for (int k = 0; k < n; k++) keep[k] = 1'b0;
    if (mode == MODE_TOGGLE) begin
      if (r < 1 || r > n || c < 1 || c > n) begin
        row_words_due.push_back(row_word_t'{bits: '0, num: '0, status: ST_RANGE, last: 1'b1});
        return;
      end
      image[r - 1][c - 1] = ~image[r - 1][c - 1];
    end else if (mode == MODE_MIRROR) begin
      for (int rr = 0; rr < n; rr++) begin
        src = image[rr];
        image[rr] = src & keep;
        for (int cc = 0; cc < n; cc++) image[rr][n - 1 - cc] = src[cc];
      end
    end else if (mode == MODE_ROTATE) begin
      prev = image;
      for (int rr = 0; rr < n; rr++) begin
        image[rr] = prev[rr] & keep;
        for (int cc = 0; cc < n; cc++) image[rr][cc] = prev[n - 1 - cc][rr];
      end
    end else begin
      row_words_due.push_back(row_word_t'{bits: '0, num: '0, status: ST_MODE, last: 1'b1});
      return;
    end
    for (int rr = 0; rr < n; rr++) begin
      row_words_due.push_back(row_word_t'{bits: image[rr] & ~keep, num: SIDE_W'(rr + 1),
                                          status: ST_OK, last: (rr == n - 1)});
    end
  endtask

  always @(posedge clk) begin : watch
    row_word_t got;
    row_word_t want;
    if (!rst_n) begin
      side_reg = SIDE_W'(MAX_SIDE);
      for (int k = 0; k < MAX_SIDE; k++) image[k] = '0;
      row_words_due.delete();
    end else begin
      if (cfg_we) begin
        side_reg = cfg_wdata;
      end
      if (out_mon.valid && out_mon.ready) begin
        got = row_word_t'{bits: out_mon.row_bits, num: out_mon.row_number,
                          status: out_mon.status, last: out_mon.last};
        if (row_words_due.size() == 0) begin
          report($sformatf("row word with nothing due: bits %h row %0d status %0d last %0d",
                           got.bits, got.num, got.status, got.last));
        end else begin
          want = row_words_due.pop_front();
          if (got.bits !== want.bits || got.num !== want.num ||
              got.status !== want.status || got.last !== want.last) begin
            report($sformatf({"row word mismatch (got/want): bits %h/%h row %0d/%0d ",
                              "status %0d/%0d last %0d/%0d"},
                             got.bits, want.bits, got.num, want.num,
                             got.status, want.status, got.last, want.last));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_request(in_mon.mode, in_mon.row, in_mon.col);
      end
    end
    words_due <= row_words_due.size();
  end

endmodule

[dv/tb_bitmap_toggle_flip_rotate.sv]
// Testbench top for the bitmap toggle/flip/rotate block: drives directed and random
// requests and side writes under random stalls, and gives the verdict from bftr_checker.
// Depends on bftr_pkg, bftr_in_if, bftr_out_if, bftr_checker and the block itself.
`timescale 1ns / 1ps

module tb_bitmap_toggle_flip_rotate;
  import bftr_pkg::*;

  localparam logic [1:0] MODE_UNKNOWN  = 2'd3;
  localparam int         STALL_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         CHUNK_ITEMS   = 16;
  localparam int         NUM_CHUNKS    = 12;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [SIDE_W-1:0] cfg_wdata;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                side_now;
  int                fail_count;
  int                words_due;
  int                quiet_cycles;
  int                side_plan [NUM_CHUNKS] = '{16, 5, 1, 2, 16, 9, 0, 31, 3, 12, 7, 16};

  bftr_in_if  in_ch ();
  bftr_out_if out_ch ();

  bitmap_toggle_flip_rotate i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  bftr_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .words_due (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_req(input logic [1:0] mode, input logic [SIDE_W-1:0] r,
                          input logic [SIDE_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.row   <= r;
    in_ch.col   <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic set_side(input logic [SIDE_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    side_now = (v == 0) ? 1 : ((v > MAX_SIDE) ? MAX_SIDE : int'(v));
  endtask

  task automatic send_random(input int count);
    int                pick;
    int                sel;
    logic [SIDE_W-1:0] r;
    logic [SIDE_W-1:0] c;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      r = SIDE_W'($urandom_range(31));
      c = SIDE_W'($urandom_range(31));
      if (pick < 50) begin
        send_req(MODE_TOGGLE, SIDE_W'($urandom_range(side_now, 1)),
                 SIDE_W'($urandom_range(side_now, 1)));
      end else if (pick < 65) begin
        send_req(MODE_MIRROR, r, c);
      end else if (pick < 80) begin
        send_req(MODE_ROTATE, r, c);
      end else if (pick < 90) begin
        sel = $urandom_range(2);
        r = SIDE_W'($urandom_range(side_now, 1));
        c = SIDE_W'($urandom_range(side_now, 1));
        if (sel != 1) begin
          r = ($urandom_range(1) == 0) ? '0 : SIDE_W'($urandom_range(31, side_now + 1));
        end
        if (sel != 0) begin
          c = ($urandom_range(1) == 0) ? '0 : SIDE_W'($urandom_range(31, side_now + 1));
        end
        send_req(MODE_TOGGLE, r, c);
      end else begin
        send_req(MODE_UNKNOWN, r, c);
      end
    end
  endtask

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb_bitmap_toggle_flip_rotate: done, errors");
    $finish;
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_TOGGLE;
    in_ch.row   <= '0;
    in_ch.col   <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    rst_n       <= 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 80;
    side_now      = MAX_SIDE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, range errors, every mode at the reset side
    send_req(MODE_TOGGLE, 1, 1);
    send_req(MODE_TOGGLE, 16, 16);
    send_req(MODE_TOGGLE, 1, 16);
    send_req(MODE_TOGGLE, 16, 1);
    send_req(MODE_TOGGLE, 0, 5);
    send_req(MODE_TOGGLE, 5, 0);
    send_req(MODE_TOGGLE, 17, 3);
    send_req(MODE_TOGGLE, 3, 17);
    send_req(MODE_TOGGLE, 31, 31);
    send_req(MODE_MIRROR, 0, 0);
    send_req(MODE_ROTATE, 31, 31);
    send_req(MODE_UNKNOWN, 0, 0);
    send_req(MODE_UNKNOWN, 31, 31);

    // side of zero acts as one; hidden pixels must survive
    set_side(0);
    send_req(MODE_TOGGLE, 1, 1);
    send_req(MODE_TOGGLE, 2, 1);
    send_req(MODE_TOGGLE, 1, 2);
    send_req(MODE_MIRROR, 5, 5);
    send_req(MODE_ROTATE, 5, 5);

    // side above the maximum saturates
    set_side(31);
    send_req(MODE_ROTATE, 0, 0);
    send_req(MODE_TOGGLE, 16, 16);
    send_req(MODE_TOGGLE, 17, 17);

    set_side(2);
    send_req(MODE_TOGGLE, 1, 2);
    send_req(MODE_ROTATE, 0, 0);
    send_req(MODE_MIRROR, 0, 0);
    send_req(MODE_TOGGLE, 3, 1);

    for (int k = 0; k < NUM_CHUNKS; k++) begin
      if (k == NUM_CHUNKS / 3) begin
        send_idle_pct = 80;
        recv_idle_pct = 10;
      end else if (k == 2 * NUM_CHUNKS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_side(SIDE_W'(side_plan[k]));
      send_random(CHUNK_ITEMS);
    end

    // drain
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_bitmap_toggle_flip_rotate: done, clean");
    end else begin
      $display("tb_bitmap_toggle_flip_rotate: done, errors");
    end
    $finish;
  end

endmodule
